// ===== src/mwo_pkg.sv =====
// shared types and constants of the mecanum wheel odometry block
// no dependencies
package mwo_pkg;

  localparam int WHEELS    = 4;
  localparam int AXES      = 3;
  localparam int QBITS     = 26;                 // quotient bits of the divider
  localparam int STEP_LAST = QBITS - 1;

  localparam logic [25:0] VEL_LIMIT = 26'd655360;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  // ceil(2^46 / 1000), exact floor division by 1000 for products below 2^36
  localparam logic [36:0] RECIP_1000 = 37'd70368744178;

  localparam logic [31:0] RPC_RESET  = 32'd103;
  localparam logic [15:0] RAD_RESET  = 16'd3277;
  localparam logic [16:0] AXS_RESET  = 17'd26214;
  localparam logic [15:0] GATE_RESET = 16'd100;

  // register indexes
  localparam logic [2:0] REG_RPC  = 3'd0;
  localparam logic [2:0] REG_RAD  = 3'd1;
  localparam logic [2:0] REG_AXS  = 3'd2;
  localparam logic [2:0] REG_GATE = 3'd3;

  // axis indexes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_TURN = 2'd2;

  typedef struct packed {
    logic       load;      // latch input word, wheel deltas, scale product
    logic       sum;       // wheel combination, divisor
    logic       mul;       // one partial product
    logic       div_ld;    // load dividend
    logic       div_init;  // range check and remainder setup
    logic       div_step;  // one quotient bit
    logic       vfin;      // velocity result, position multiplicand
    logic       pfin;      // position update
    logic       out_load;  // fill output registers
    logic       mode_pos;  // multiplier works on position delta
    logic [1:0] axis;
    logic [1:0] pp;
  } cmd_t;

  typedef struct packed {
    logic off;
  } status_t;

endpackage

// ===== src/mwo_ctrl.sv =====
// sequencer of the mecanum wheel odometry block
// depends on mwo_pkg
module mwo_ctrl
  import mwo_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SUM   = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_DLD   = 9'b000001000,
    ST_DINIT = 9'b000010000,
    ST_DSTEP = 9'b000100000,
    ST_VFIN  = 9'b001000000,
    ST_PFIN  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        mode_r, mode_nxt;
  logic        ov_r, ov_nxt;
  logic        out_free;

  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    mode_nxt  = mode_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.pp    = cnt_r[1:0];
    cmd.mode_pos = mode_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = AXIS_X;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.off) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.sum   = 1'b1;
          cnt_nxt   = '0;
          mode_nxt  = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = mode_r ? ST_PFIN : ST_DLD;
        end
      end
      ST_DLD: begin
        cmd.div_ld = 1'b1;
        state_nxt  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(STEP_LAST)) begin
          state_nxt = ST_VFIN;
        end
      end
      ST_VFIN: begin
        cmd.vfin  = 1'b1;
        mode_nxt  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_PFIN: begin
        cmd.pfin = 1'b1;
        if (axis_r == AXIS_TURN) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_SUM;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= AXIS_X;
      mode_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      mode_r  <= mode_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== src/mwo_datapath.sv =====
// arithmetic, state and output registers of the mecanum wheel odometry block
// depends on mwo_pkg
module mwo_datapath
  import mwo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_count_front_left,
  input  logic signed [31:0] in_count_front_right,
  input  logic signed [31:0] in_count_rear_left,
  input  logic signed [31:0] in_count_rear_right,
  input  logic [15:0]        in_elapsed_ms,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [20:0] out_vel_x,
  output logic signed [20:0] out_vel_y,
  output logic signed [20:0] out_vel_turn,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_heading,
  output logic               out_motors_off
);

  logic [31:0] rpc_r;
  logic [15:0] rad_r;
  logic [16:0] axs_r;
  logic [15:0] gate_r;

  logic [15:0] ms_r;
  logic        off_r;
  logic [31:0] prev_r [WHEELS];
  logic [31:0] d_r    [WHEELS];
  logic [47:0] k_r;
  logic [43:0] a_r;
  logic        sign_r;
  logic [34:0] dv_r;
  logic [91:0] acc_r;
  logic [75:0] x_r;
  logic [34:0] rem_r;
  logic [25:0] low_r;
  logic [25:0] q_r;
  logic        zero_r;
  logic signed [20:0] vel_r [AXES];
  logic [31:0] pos_r [AXES];

  logic [31:0] cur      [WHEELS];
  logic        off_now;
  logic signed [34:0] dx [WHEELS];
  logic signed [34:0] s;
  logic [33:0] s_mag;
  logic [47:0] k_src;
  logic [21:0] a_part;
  logic [23:0] k_part;
  logic [45:0] prod;
  logic [91:0] prod_sh;
  logic [49:0] hi;
  logic [35:0] trial;
  logic        ge;
  logic        vok;
  logic [19:0] vmag;
  logic [31:0] qmag;

  assign cur[0] = in_count_front_left;
  assign cur[1] = in_count_front_right;
  assign cur[2] = in_count_rear_left;
  assign cur[3] = in_count_rear_right;
  assign off_now = in_elapsed_ms > gate_r;
  assign status.off = off_r;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      dx[i] = 35'(signed'(d_r[i]));
    end
    case (cmd.axis)
      AXIS_X:    s = dx[0] - dx[1] - dx[2] + dx[3];
      AXIS_Y:    s = dx[2] + dx[3] - dx[0] - dx[1];
      default:   s = dx[0] + dx[1] + dx[2] + dx[3];
    endcase
    s_mag   = s[34] ? 34'(-s) : s[33:0];
    k_src   = cmd.mode_pos ? 48'(RECIP_1000) : k_r;
    a_part  = cmd.pp[0] ? a_r[43:22] : a_r[21:0];
    k_part  = cmd.pp[1] ? k_src[47:24] : k_src[23:0];
    prod    = 46'(a_part) * 46'(k_part);
    prod_sh = 92'(prod) << ((cmd.pp[0] ? 7'd22 : 7'd0) + (cmd.pp[1] ? 7'd24 : 7'd0));
    hi      = x_r[75:26];
    trial   = {rem_r, low_r[25]};
    ge      = trial >= {1'b0, dv_r};
    vok     = !zero_r && (q_r < VEL_LIMIT);
    vmag    = vok ? q_r[19:0] : 20'd0;
    // position delta magnitude: product shifted down by 46, below 2^26
    qmag    = 32'(acc_r[71:46]);
  end

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpc_r  <= RPC_RESET;
      rad_r  <= RAD_RESET;
      axs_r  <= AXS_RESET;
      gate_r <= GATE_RESET;
      for (int i = 0; i < WHEELS; i++) prev_r[i] <= '0;
      for (int i = 0; i < AXES; i++) pos_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RPC:  rpc_r  <= cfg_data;
          REG_RAD:  rad_r  <= cfg_data[15:0];
          REG_AXS:  axs_r  <= cfg_data[16:0];
          REG_GATE: gate_r <= cfg_data[15:0];
          default:  ;
        endcase
      end
      if (cmd.load && !off_now) begin
        for (int i = 0; i < WHEELS; i++) prev_r[i] <= cur[i];
      end
      if (cmd.pfin) begin
        pos_r[cmd.axis] <= pos_r[cmd.axis] + (sign_r ? -qmag : qmag);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms_r  <= in_elapsed_ms;
      off_r <= off_now;
      for (int i = 0; i < WHEELS; i++) d_r[i] <= cur[i] - prev_r[i];
      for (int i = 0; i < AXES; i++) vel_r[i] <= '0;
      k_r   <= 48'(rpc_r) * 48'(rad_r);
    end
    if (cmd.sum) begin
      sign_r <= s[34];
      a_r    <= 44'(s_mag) * 44'(MS_PER_S);
      dv_r   <= (cmd.axis == AXIS_TURN) ? 35'({ms_r, 2'b00}) * 35'(axs_r)
                                        : 35'({ms_r, 2'b00});
      acc_r  <= '0;
    end
    if (cmd.mul) begin
      acc_r <= acc_r + prod_sh;
    end
    if (cmd.div_ld) begin
      x_r <= (cmd.axis == AXIS_TURN) ? acc_r[91:16] : 76'(acc_r[91:32]);
    end
    if (cmd.div_init) begin
      zero_r <= hi >= 50'(dv_r);
      rem_r  <= hi[34:0];
      low_r  <= x_r[25:0];
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 35'(trial - {1'b0, dv_r}) : trial[34:0];
      low_r <= {low_r[24:0], 1'b0};
      q_r   <= {q_r[24:0], ge};
    end
    if (cmd.vfin) begin
      vel_r[cmd.axis] <= sign_r ? -signed'(21'(vmag)) : signed'(21'(vmag));
      // velocity times dt, then scaled by the reciprocal of 1000
      a_r             <= 44'(vmag) * 44'(ms_r);
      acc_r           <= '0;
    end
    if (cmd.out_load) begin
      out_vel_x       <= vel_r[0];
      out_vel_y       <= vel_r[1];
      out_vel_turn    <= vel_r[2];
      out_pos_x       <= pos_r[0];
      out_pos_y       <= pos_r[1];
      out_pos_heading <= pos_r[2];
      out_motors_off  <= off_r;
    end
  end

endmodule

// ===== src/mecanum_wheel_odometry.sv =====
// top level of the mecanum wheel odometry block
// depends on mwo_pkg, mwo_ctrl, mwo_datapath
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  four wheel counts, elapsed_ms
// out_      output     out_valid/out_stall  velocities, positions, motors_off
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// each accepted word runs through every axis in turn before its result is loaded: per axis a wheel
// sum, four partial products, a 26 step restoring division for the velocity and
// four more partial products that scale the position delta by the reciprocal of
// 1000; the serial division is the longest of these steps.
// a gated word (elapsed time above the limit) skips the arithmetic and goes straight to the load.
// the next word can be taken from the cycle after the load, and not before it.
// reset is synchronous, active low, and loads register defaults and zero state.
// a result waiting on out_stall does not block the next input word; only the
// final load into the output register waits for it.
module mecanum_wheel_odometry
  import mwo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_count_front_left,
  input  logic signed [31:0] in_count_front_right,
  input  logic signed [31:0] in_count_rear_left,
  input  logic signed [31:0] in_count_rear_right,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [20:0] out_vel_x,
  output logic signed [20:0] out_vel_y,
  output logic signed [20:0] out_vel_turn,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_heading,
  output logic               out_motors_off
);

  cmd_t    cmd;     // sequencer to datapath
  status_t status;  // datapath back to sequencer

  // sequencer: walks each axis through sum, multiply, division and position scaling
  mwo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config, previous counts, accumulators, shared multiplier/divider
  mwo_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_count_front_left  (in_count_front_left),
    .in_count_front_right (in_count_front_right),
    .in_count_rear_left   (in_count_rear_left),
    .in_count_rear_right  (in_count_rear_right),
    .in_elapsed_ms        (in_elapsed_ms),
    .cmd                  (cmd),
    .status               (status),
    .out_vel_x            (out_vel_x),
    .out_vel_y            (out_vel_y),
    .out_vel_turn         (out_vel_turn),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_pos_heading      (out_pos_heading),
    .out_motors_off       (out_motors_off)
  );

endmodule
